[sv/analog_pad_serial_responder_assert.svh]
// Assertion helpers used by the pad responder top module.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ANALOG_PAD_SERIAL_RESPONDER_ASSERT_SVH
`define ANALOG_PAD_SERIAL_RESPONDER_ASSERT_SVH

// Same-cycle implication.
`define APSR_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pad responder check failed: same-cycle implication");

// Next-cycle implication.
`define APSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pad responder check failed: next-cycle implication");

`endif

[sv/apsr_pkg.sv]
package apsr_pkg;

   // Protocol bytes
   localparam logic [7:0] START_BYTE = 8'h01;
   localparam logic [7:0] ID_DIGITAL = 8'h53;
   localparam logic [7:0] ID_ANALOG  = 8'h73;
   localparam logic [7:0] DATA_MARK  = 8'h5A;
   localparam logic [7:0] READ_CMD   = 8'h42;
   localparam logic [7:0] ALL_ONES   = 8'hFF;

   // Transmit queue geometry
   localparam int TX_DEPTH = 8;
   localparam logic [3:0] TX_ID_COUNT   = 4'd1;
   localparam logic [3:0] TX_POLL_COUNT = 4'd7;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_CMD   = 2'd1,
      PH_DATA  = 2'd2,
      PH_ABORT = 2'd3
   } phase_type;

   typedef struct packed {
      logic       select_line;
      logic       clock_strobe;
      logic       txd;
      logic [7:0] buttons_first;
      logic [7:0] buttons_second;
      logic [7:0] right_x;
      logic [7:0] right_y;
      logic [7:0] left_x;
      logic [7:0] left_y;
   } req_type;

   typedef struct packed {
      logic rxd;
      logic ack_level;
      logic ack_pulse;
      logic pad_polled;
   } rsp_type;

endpackage

[sv/apsr_engine.sv]
module apsr_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  apsr_pkg::req_type req,
   input  logic             digital_mode,
   output apsr_pkg::rsp_type rsp
);
   import apsr_pkg::*;

   logic       select_prev_ff, select_prev_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic [2:0] tx_index_ff, tx_index_in;
   logic [3:0] tx_remaining_ff, tx_remaining_in;
   logic [7:0] tx_bytes_ff [TX_DEPTH];
   logic [7:0] tx_bytes_in [TX_DEPTH];

   // Work out one transaction step: select edge first, then the clock strobe
   always_comb begin
      logic       rise;
      logic       clk_bit;
      logic       byte_done;
      logic [7:0] tx_cur;
      phase_type  ph;
      logic [2:0] bi;
      logic [2:0] ti;
      logic [3:0] tr;
      logic [7:0] rx;

      rise    = !select_prev_ff && req.select_line;
      clk_bit = req.clock_strobe && req.select_line;

      ph = rise ? PH_START : phase_ff;
      bi = rise ? 3'd0 : bit_index_ff;
      ti = rise ? 3'd0 : tx_index_ff;
      tr = rise ? 4'd0 : tx_remaining_ff;
      rx = rx_shift_ff;

      for (int i = 0; i < TX_DEPTH; i++) begin
         tx_bytes_in[i] = tx_bytes_ff[i];
      end

      tx_cur         = tx_bytes_ff[ti];
      rsp.rxd        = 1'b1;
      rsp.ack_pulse  = 1'b0;
      rsp.pad_polled = 1'b0;
      byte_done      = 1'b0;

      if (clk_bit) begin
         if (tr != 4'd0) begin
            rsp.rxd = tx_cur[bi];
         end
         rx[bi]    = req.txd;
         bi        = bi + 3'd1;
         byte_done = (bi == 3'd0);
      end

      // Close a byte: advance the queue, then decode what the host sent
      if (byte_done) begin
         if (tr != 4'd0) begin
            ti = ti + 3'd1;
            tr = tr - 4'd1;
         end
         unique case (ph)
            PH_START: begin
               if (rx != START_BYTE) begin
                  ph = PH_ABORT;
               end else begin
                  tx_bytes_in[0] = digital_mode ? ID_DIGITAL : ID_ANALOG;
                  ti = 3'd0;
                  tr = TX_ID_COUNT;
                  ph = PH_CMD;
               end
            end
            PH_CMD: begin
               tx_bytes_in[0] = DATA_MARK;
               if (rx == READ_CMD) begin
                  tx_bytes_in[1] = ALL_ONES ^ req.buttons_first;
                  tx_bytes_in[2] = ALL_ONES ^ req.buttons_second;
                  tx_bytes_in[3] = req.right_x;
                  tx_bytes_in[4] = req.right_y;
                  tx_bytes_in[5] = req.left_x;
                  tx_bytes_in[6] = req.left_y;
                  ti = 3'd0;
                  tr = TX_POLL_COUNT;
                  ph = PH_DATA;
                  rsp.pad_polled = 1'b1;
               end else begin
                  tx_bytes_in[1] = 8'd0;
                  tx_bytes_in[2] = 8'd0;
                  ti = 3'd0;
                  tr = 4'd0;
                  ph = PH_ABORT;
               end
            end
            PH_DATA, PH_ABORT: begin
               // keep receiving, no reaction
            end
         endcase
         rsp.ack_pulse = (tr != 4'd0);
      end

      rsp.ack_level = req.select_line && (bi == 3'd0) && (tr != 4'd0);

      select_prev_in  = req.select_line;
      phase_in        = ph;
      bit_index_in    = bi;
      rx_shift_in     = rx;
      tx_index_in     = ti;
      tx_remaining_in = tr;
   end

   // Commit the step when a transaction is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         select_prev_ff  <= 1'b0;
         phase_ff        <= PH_START;
         bit_index_ff    <= 3'd0;
         rx_shift_ff     <= 8'd0;
         tx_index_ff     <= 3'd0;
         tx_remaining_ff <= 4'd0;
         for (int i = 0; i < TX_DEPTH; i++) begin
            tx_bytes_ff[i] <= 8'd0;
         end
      end else if (step) begin
         select_prev_ff  <= select_prev_in;
         phase_ff        <= phase_in;
         bit_index_ff    <= bit_index_in;
         rx_shift_ff     <= rx_shift_in;
         tx_index_ff     <= tx_index_in;
         tx_remaining_ff <= tx_remaining_in;
         for (int i = 0; i < TX_DEPTH; i++) begin
            tx_bytes_ff[i] <= tx_bytes_in[i];
         end
      end
   end

endmodule

[sv/analog_pad_serial_responder.sv]
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register stalls
// the request side only while a held result is itself stalled.
// Reset (synchronous, active high): pad state, transmit queue and the
// digital stick mode clear to zero; the result register empties.
module analog_pad_serial_responder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  apsr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output apsr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import apsr_pkg::*;
   `include "analog_pad_serial_responder_assert.svh"

   logic    mode_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_rsp;
   logic    req_take;

   // Accept whenever the result register is free or draining this cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   apsr_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (req_take),
      .req          (req_data),
      .digital_mode (mode_ff),
      .rsp          (step_rsp)
   );

   // Hold a result until taken; load the next one behind it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `APSR_ASSERT_IMPLY(a_pulse_has_ack, rsp_valid_ff && rsp_data_ff.ack_pulse, rsp_data_ff.ack_level)
   `APSR_ASSERT_IMPLY(a_poll_has_pulse, rsp_valid_ff && rsp_data_ff.pad_polled, rsp_data_ff.ack_pulse)
   `APSR_ASSERT_NEXT(a_take_gives_result, req_take, rsp_valid_ff)

endmodule
